### rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the differential drive odometry
// Item structs, configuration register indexes, back-end states and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int RAD_W   = 16;
    localparam int RATE_W  = 10;
    localparam int MAG_W   = 32;   // |rate * radius| < 2^31
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;
    localparam int CNT_W   = 6;    // longest loop is 53 iterations
    localparam int ANG_IDX_W = 5;  // arctangent table has 24 entries

    localparam int WDIV_ITERS = 32;
    localparam int HDIV_ITERS = 53;
    localparam int MUL_ITERS  = 33;

    localparam logic [2:0] CFG_LEFT_RADIUS  = 3'd0;
    localparam logic [2:0] CFG_RIGHT_RADIUS = 3'd1;
    localparam logic [2:0] CFG_HALF_BASE    = 3'd2;
    localparam logic [2:0] CFG_UPDATE_RATE  = 3'd3;

    localparam logic [15:0] RESET_RADIUS    = 16'd1280;
    localparam logic [15:0] RESET_HALF_BASE = 16'd2733;
    localparam logic [9:0]  RESET_RATE      = 10'd100;

    localparam logic [17:0] PI_Q16 = 18'd205887;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] left_wheel_rate;
        logic signed [15:0] right_wheel_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading_out;
        logic signed [15:0] heading_step;
        logic               pos_saturated;
    } out_item_t;

    typedef struct packed {
        logic [RAD_W-1:0]  left_radius;
        logic [RAD_W-1:0]  right_radius;
        logic [RAD_W-1:0]  half_base;
        logic [RATE_W-1:0] update_rate;
    } cfg_regs_t;

    // sign/magnitude wheel products, ready for the divider
    typedef struct packed {
        logic             neg_l;
        logic [MAG_W-1:0] mag_l;
        logic             neg_r;
        logic [MAG_W-1:0] mag_r;
    } work_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WDIV, ST_DSIGN, ST_DSUM, ST_HPREP, ST_HDIV, ST_HUPD,
        ST_CINIT, ST_CORD, ST_CEND, ST_MUL, ST_MEND, ST_POSE
    } back_state_t;

    function automatic logic signed [33:0] cordic_angle(input logic [ANG_IDX_W-1:0] idx);
        logic signed [33:0] a;
        case (idx)
            5'd0:  a = 34'sd536870912;
            5'd1:  a = 34'sd316933406;
            5'd2:  a = 34'sd167458907;
            5'd3:  a = 34'sd85004756;
            5'd4:  a = 34'sd42667331;
            5'd5:  a = 34'sd21354465;
            5'd6:  a = 34'sd10679838;
            5'd7:  a = 34'sd5340245;
            5'd8:  a = 34'sd2670163;
            5'd9:  a = 34'sd1335087;
            5'd10: a = 34'sd667544;
            5'd11: a = 34'sd333772;
            5'd12: a = 34'sd166886;
            5'd13: a = 34'sd83443;
            5'd14: a = 34'sd41722;
            5'd15: a = 34'sd20861;
            5'd16: a = 34'sd10430;
            5'd17: a = 34'sd5215;
            5'd18: a = 34'sd2608;
            5'd19: a = 34'sd1304;
            5'd20: a = 34'sd652;
            5'd21: a = 34'sd326;
            5'd22: a = 34'sd163;
            5'd23: a = 34'sd81;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

endpackage

### rtl/differential_drive_odometry.sv
// Path: an input sample passes the front stage register and the work queue, then the
//   back-end sequencer; the result also waits on out_ready while the last is held.
// The back-end sequencer starts a new sample only from idle, after the whole
//   sequence (32-step wheel divide, 53-step heading divide, CORDIC, 33-step multiply).
// A two-entry queue lets up to three samples be accepted ahead of the sequencer.
// Reset (rst_n low, async): pose and heading cleared, registers to defaults.
// ----------------------------------------------------------------------------
// differential_drive_odometry: dead-reckoning pose from wheel rates
// Front stage forms rate * radius per wheel, a short queue buffers the work,
// and the back sequencer updates heading, x and y.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 16   // 8..24 rotation steps
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ddo_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ddo_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_data
);

    // Configuration registers; the user must write them only while the block is idle,
    // so the back end reads them live; the block itself does not enforce it.
    ddo_pkg::cfg_regs_t cfg_reg;

    // Front-to-queue and queue-to-back transfers
    logic           push, pop, q_full, q_empty;
    ddo_pkg::work_t push_data, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_radius  <= ddo_pkg::RESET_RADIUS;
            cfg_reg.right_radius <= ddo_pkg::RESET_RADIUS;
            cfg_reg.half_base    <= ddo_pkg::RESET_HALF_BASE;
            cfg_reg.update_rate  <= ddo_pkg::RESET_RATE;
        end
        else if (cfg_we)
        begin
            // unknown indexes are dropped
            unique case (cfg_addr)
                ddo_pkg::CFG_LEFT_RADIUS:  cfg_reg.left_radius  <= cfg_data;
                ddo_pkg::CFG_RIGHT_RADIUS: cfg_reg.right_radius <= cfg_data;
                ddo_pkg::CFG_HALF_BASE:    cfg_reg.half_base    <= cfg_data;
                ddo_pkg::CFG_UPDATE_RATE:  cfg_reg.update_rate  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Input stage: registered wheel products in sign/magnitude form
    ddo_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .left_radius  (cfg_reg.left_radius),
        .right_radius (cfg_reg.right_radius),
        .push         (push),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    // Work queue between the two halves
    ddo_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: divides, CORDIC, multiply, pose accumulate, result register
    ddo_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/ddo_front.sv
// ----------------------------------------------------------------------------
// ddo_front: input stage
// Accepts wheel-rate samples, forms rate * radius per wheel and hands the
// sign/magnitude pair to the work queue.
// ----------------------------------------------------------------------------
module ddo_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ddo_pkg::in_item_t          in_data,
    input  logic [ddo_pkg::RAD_W-1:0]  left_radius,
    input  logic [ddo_pkg::RAD_W-1:0]  right_radius,
    output logic                       push,
    output ddo_pkg::work_t             push_data,
    input  logic                       q_full
);

    logic           stage_valid_reg, stage_valid_next;
    ddo_pkg::work_t stage_reg;
    logic signed [32:0] prod_l, prod_r, abs_l, abs_r;
    logic accept;

    assign in_ready = !stage_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = stage_valid_reg && !q_full;
    assign push_data = stage_reg;

    assign prod_l = 33'(in_data.left_wheel_rate) * 33'($signed({1'b0, left_radius}));
    assign prod_r = 33'(in_data.right_wheel_rate) * 33'($signed({1'b0, right_radius}));
    assign abs_l  = prod_l[32] ? -prod_l : prod_l;
    assign abs_r  = prod_r[32] ? -prod_r : prod_r;

    assign stage_valid_next = accept || (stage_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.neg_l <= prod_l[32];
            stage_reg.mag_l <= abs_l[31:0];
            stage_reg.neg_r <= prod_r[32];
            stage_reg.mag_r <= abs_r[31:0];
        end
    end

endmodule

### rtl/ddo_queue.sv
// ----------------------------------------------------------------------------
// ddo_queue: two-entry work queue
// Decouples the input stage from the back-end sequencer.
// ----------------------------------------------------------------------------
module ddo_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ddo_pkg::work_t push_data,
    input  logic           pop,
    output ddo_pkg::work_t head,
    output logic           full,
    output logic           empty
);

    ddo_pkg::work_t entry_reg [ddo_pkg::QDEPTH];
    logic [ddo_pkg::QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [ddo_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == ddo_pkg::QCNT_W'(ddo_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push) else $error("queue overflow");
`endif

endmodule

### rtl/ddo_back.sv
// ----------------------------------------------------------------------------
// ddo_back: pose update sequencer
// Serial wheel divide, heading divide, CORDIC, serial multiply and
// saturating pose accumulate; holds the pose and the result register.
// ----------------------------------------------------------------------------
module ddo_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ddo_pkg::cfg_regs_t cfg,
    input  logic               q_empty,
    input  ddo_pkg::work_t     q_head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output ddo_pkg::out_item_t out_data
);

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    ddo_pkg::back_state_t state_reg, state_next;
    logic [ddo_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic [15:0] heading_reg, heading_next;
    logic out_valid_reg, out_valid_next;
    ddo_pkg::out_item_t out_data_reg, out_data_next;

    // datapath registers
    logic neg_l_reg, neg_l_next, neg_r_reg, neg_r_next;
    logic [31:0] num_l_reg, num_l_next, num_r_reg, num_r_next;
    logic [10:0] rem_l_reg, rem_l_next, rem_r_reg, rem_r_next;
    logic signed [32:0] dl_reg, dl_next, dr_reg, dr_next;
    logic signed [33:0] diff_reg, diff_next, sum_reg, sum_next;
    logic [33:0] den_reg, den_next;
    logic hneg_reg, hneg_next;
    logic [52:0] dvd_reg, dvd_next;
    logic [34:0] hrem_reg, hrem_next;
    logic [15:0] step_reg, step_next;
    logic signed [33:0] z_reg, z_next, cx_reg, cx_next, cy_reg, cy_next;
    logic fold_reg, fold_next;
    logic [32:0] mplier_reg, mplier_next, mcx_reg, mcx_next, mcy_reg, mcy_next;
    logic sgnx_reg, sgnx_next, sgny_reg, sgny_next;
    logic [65:0] accx_reg, accx_next, accy_reg, accy_next;
    logic signed [33:0] dx_reg, dx_next, dy_reg, dy_next;

    // combinational temporaries
    logic [9:0]  f_eff;
    logic [15:0] hb_eff;
    logic [10:0] lsh, rsh;
    logic        lge, rge, hge;
    logic [34:0] hsh;
    logic signed [33:0] dmag, csh_x, csh_y, ang, cmag_x, cmag_y, smag, z0;
    logic signed [66:0] tx, ty;
    logic signed [34:0] xs, ys;
    logic satx, saty;
    logic [15:0] stepw;

    assign pop       = (state_reg == ddo_pkg::ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign f_eff  = (cfg.update_rate == '0) ? 10'd1 : cfg.update_rate;
    assign hb_eff = (cfg.half_base == '0) ? 16'd1 : cfg.half_base;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        heading_next   = heading_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        neg_l_next = neg_l_reg;   neg_r_next = neg_r_reg;
        num_l_next = num_l_reg;   num_r_next = num_r_reg;
        rem_l_next = rem_l_reg;   rem_r_next = rem_r_reg;
        dl_next    = dl_reg;      dr_next    = dr_reg;
        diff_next  = diff_reg;    sum_next   = sum_reg;
        den_next   = den_reg;     hneg_next  = hneg_reg;
        dvd_next   = dvd_reg;     hrem_next  = hrem_reg;
        step_next  = step_reg;
        z_next     = z_reg;       cx_next    = cx_reg;   cy_next = cy_reg;
        fold_next  = fold_reg;
        mplier_next = mplier_reg; mcx_next = mcx_reg;    mcy_next = mcy_reg;
        sgnx_next  = sgnx_reg;    sgny_next  = sgny_reg;
        accx_next  = accx_reg;    accy_next  = accy_reg;
        dx_next    = dx_reg;      dy_next    = dy_reg;

        lsh   = {rem_l_reg[9:0], num_l_reg[31]};
        rsh   = {rem_r_reg[9:0], num_r_reg[31]};
        lge   = (lsh >= {1'b0, f_eff});
        rge   = (rsh >= {1'b0, f_eff});
        hsh   = {hrem_reg[33:0], dvd_reg[52]};
        hge   = (hsh >= {1'b0, den_reg});
        dmag  = diff_reg[33] ? -diff_reg : diff_reg;
        ang   = ddo_pkg::cordic_angle(cnt_reg[ddo_pkg::ANG_IDX_W-1:0]);
        csh_x = cy_reg >>> cnt_reg[ddo_pkg::ANG_IDX_W-1:0];
        csh_y = cx_reg >>> cnt_reg[ddo_pkg::ANG_IDX_W-1:0];
        cmag_x = cx_reg[33] ? -cx_reg : cx_reg;
        cmag_y = cy_reg[33] ? -cy_reg : cy_reg;
        smag  = sum_reg[33] ? -sum_reg : sum_reg;
        z0    = 34'($signed({heading_reg, 16'b0}));
        stepw = hneg_reg ? -dvd_reg[15:0] : dvd_reg[15:0];
        tx    = sgnx_reg ? (67'sd4294967296 - $signed({1'b0, accx_reg}))
                         : ($signed({1'b0, accx_reg}) + 67'sd4294967296);
        ty    = sgny_reg ? (67'sd4294967296 - $signed({1'b0, accy_reg}))
                         : ($signed({1'b0, accy_reg}) + 67'sd4294967296);
        xs    = 35'(x_reg) + 35'(dx_reg);
        ys    = 35'(y_reg) + 35'(dy_reg);
        satx  = (xs[34:31] != 4'b0000) && (xs[34:31] != 4'b1111);
        saty  = (ys[34:31] != 4'b0000) && (ys[34:31] != 4'b1111);

        unique case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    neg_l_next = q_head.neg_l;
                    num_l_next = q_head.mag_l;
                    neg_r_next = q_head.neg_r;
                    num_r_next = q_head.mag_r;
                    rem_l_next = '0;
                    rem_r_next = '0;
                    cnt_next   = '0;
                    state_next = ddo_pkg::ST_WDIV;
                end
            end
            ddo_pkg::ST_WDIV:
            begin
                rem_l_next = lge ? lsh - {1'b0, f_eff} : lsh;
                rem_r_next = rge ? rsh - {1'b0, f_eff} : rsh;
                num_l_next = {num_l_reg[30:0], lge};
                num_r_next = {num_r_reg[30:0], rge};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == ddo_pkg::CNT_W'(ddo_pkg::WDIV_ITERS - 1))
                    state_next = ddo_pkg::ST_DSIGN;
            end
            ddo_pkg::ST_DSIGN:
            begin
                dl_next = neg_l_reg ? -$signed({1'b0, num_l_reg}) : $signed({1'b0, num_l_reg});
                dr_next = neg_r_reg ? -$signed({1'b0, num_r_reg}) : $signed({1'b0, num_r_reg});
                state_next = ddo_pkg::ST_DSUM;
            end
            ddo_pkg::ST_DSUM:
            begin
                diff_next  = 34'(dr_reg) - 34'(dl_reg);
                sum_next   = 34'(dl_reg) + 34'(dr_reg);
                den_next   = {18'b0, hb_eff} * {16'b0, ddo_pkg::PI_Q16};
                state_next = ddo_pkg::ST_HPREP;
            end
            ddo_pkg::ST_HPREP:
            begin
                hneg_next  = diff_reg[33];
                dvd_next   = {dmag[32:0], 20'b0} + {20'b0, den_reg[33:1]};
                hrem_next  = '0;
                cnt_next   = '0;
                state_next = ddo_pkg::ST_HDIV;
            end
            ddo_pkg::ST_HDIV:
            begin
                hrem_next = hge ? hsh - {1'b0, den_reg} : hsh;
                dvd_next  = {dvd_reg[51:0], hge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ddo_pkg::CNT_W'(ddo_pkg::HDIV_ITERS - 1))
                    state_next = ddo_pkg::ST_HUPD;
            end
            ddo_pkg::ST_HUPD:
            begin
                step_next    = stepw;
                heading_next = heading_reg + stepw;
                state_next   = ddo_pkg::ST_CINIT;
            end
            ddo_pkg::ST_CINIT:
            begin
                // fold into [-90, 90] degrees, negate the vector later
                if (z0 > 34'sd1073741824)
                begin
                    z_next    = z0 - 34'sd2147483648;
                    fold_next = 1'b1;
                end
                else if (z0 < -34'sd1073741824)
                begin
                    z_next    = z0 + 34'sd2147483648;
                    fold_next = 1'b1;
                end
                else
                begin
                    z_next    = z0;
                    fold_next = 1'b0;
                end
                cx_next    = ddo_pkg::CORDIC_GAIN;
                cy_next    = '0;
                cnt_next   = '0;
                state_next = ddo_pkg::ST_CORD;
            end
            ddo_pkg::ST_CORD:
            begin
                if (!z_reg[33])
                begin
                    cx_next = cx_reg - csh_x;
                    cy_next = cy_reg + csh_y;
                    z_next  = z_reg - ang;
                end
                else
                begin
                    cx_next = cx_reg + csh_x;
                    cy_next = cy_reg - csh_y;
                    z_next  = z_reg + ang;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ddo_pkg::CNT_W'(CORDIC_STEPS - 1))
                    state_next = ddo_pkg::ST_CEND;
            end
            ddo_pkg::ST_CEND:
            begin
                mplier_next = smag[32:0];
                mcx_next    = cmag_x[32:0];
                mcy_next    = cmag_y[32:0];
                sgnx_next   = sum_reg[33] ^ fold_reg ^ cx_reg[33];
                sgny_next   = sum_reg[33] ^ fold_reg ^ cy_reg[33];
                accx_next   = '0;
                accy_next   = '0;
                cnt_next    = '0;
                state_next  = ddo_pkg::ST_MUL;
            end
            ddo_pkg::ST_MUL:
            begin
                accx_next   = {accx_reg[64:0], 1'b0} + (mplier_reg[32] ? {33'b0, mcx_reg} : 66'b0);
                accy_next   = {accy_reg[64:0], 1'b0} + (mplier_reg[32] ? {33'b0, mcy_reg} : 66'b0);
                mplier_next = {mplier_reg[31:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == ddo_pkg::CNT_W'(ddo_pkg::MUL_ITERS - 1))
                    state_next = ddo_pkg::ST_MEND;
            end
            ddo_pkg::ST_MEND:
            begin
                // round half up, then floor shift by 33
                dx_next    = tx[66:33];
                dy_next    = ty[66:33];
                state_next = ddo_pkg::ST_POSE;
            end
            ddo_pkg::ST_POSE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    x_next = satx ? (xs[34] ? POS_MIN : POS_MAX) : xs[31:0];
                    y_next = saty ? (ys[34] ? POS_MIN : POS_MAX) : ys[31:0];
                    out_data_next.pos_x         = x_next;
                    out_data_next.pos_y         = y_next;
                    out_data_next.heading_out   = heading_reg;
                    out_data_next.heading_step  = step_reg;
                    out_data_next.pos_saturated = satx || saty;
                    out_valid_next = 1'b1;
                    state_next     = ddo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ddo_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddo_pkg::ST_IDLE;
            cnt_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            heading_reg   <= heading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        neg_l_reg <= neg_l_next;   neg_r_reg <= neg_r_next;
        num_l_reg <= num_l_next;   num_r_reg <= num_r_next;
        rem_l_reg <= rem_l_next;   rem_r_reg <= rem_r_next;
        dl_reg    <= dl_next;      dr_reg    <= dr_next;
        diff_reg  <= diff_next;    sum_reg   <= sum_next;
        den_reg   <= den_next;     hneg_reg  <= hneg_next;
        dvd_reg   <= dvd_next;     hrem_reg  <= hrem_next;
        step_reg  <= step_next;
        z_reg     <= z_next;       cx_reg    <= cx_next;    cy_reg <= cy_next;
        fold_reg  <= fold_next;
        mplier_reg <= mplier_next; mcx_reg <= mcx_next;     mcy_reg <= mcy_next;
        sgnx_reg  <= sgnx_next;    sgny_reg  <= sgny_next;
        accx_reg  <= accx_next;    accy_reg  <= accy_next;
        dx_reg    <= dx_next;      dy_reg    <= dy_next;
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty) else $error("pop from empty queue");
    a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ddo_pkg::ST_CORD |-> cnt_reg < ddo_pkg::CNT_W'(CORDIC_STEPS))
        else $error("CORDIC ran past its step count");
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.pos_saturated |->
            out_data_reg.pos_x == POS_MAX || out_data_reg.pos_x == POS_MIN ||
            out_data_reg.pos_y == POS_MAX || out_data_reg.pos_y == POS_MIN)
        else $error("saturation flag without clipped position");
    a_pose_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ddo_pkg::ST_POSE && (!out_valid_reg || out_ready) |=>
            out_valid_reg && state_reg == ddo_pkg::ST_IDLE)
        else $error("result not presented after pose update");
`endif

endmodule

### test/differential_drive_odometry_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_tb: self-checking regression of the odometry
// A directed table of samples and register writes, then randomized phases,
// each sample checked against a cycle-free pose predictor in the bench or a typed-in pose.
// ----------------------------------------------------------------------------
module differential_drive_odometry_tb;

    localparam int         STEPS       = 16;      // CORDIC steps of the instance
    localparam int         QUIET_LIMIT = 20000;   // cycles with no transfer at all
    localparam int         HOLD_LEN    = 3000;    // long receiver hold-off
    localparam int         DRAIN_WAIT  = 200;     // exceeds the latency of one sample
    localparam int         RAND_PHASES = 10;
    localparam int         PHASE_ITEMS = 95;
    localparam logic [2:0] CFG_UNUSED  = 3'd5;    // no register at this index

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [2:0]         addr;
        logic [15:0]        value;
        ddo_pkg::in_item_t  sample;
        bit                 fixed;     // expected pose typed in below
        ddo_pkg::out_item_t pose;
    } stim_row_t;

    // arctangent table, 2^32 per turn
    localparam longint ATAN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    ddo_pkg::in_item_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    ddo_pkg::out_item_t out_data;
    logic               cfg_we    = 1'b0;
    logic [2:0]         cfg_addr  = '0;
    logic [15:0]        cfg_data  = '0;

    differential_drive_odometry #(.CORDIC_STEPS(STEPS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // bench copy of the registers and the pose
    logic [15:0] left_radius;
    logic [15:0] right_radius;
    logic [15:0] half_base;
    logic [9:0]  update_rate;
    longint      pose_x;
    longint      pose_y;
    logic [15:0] heading;

    ddo_pkg::out_item_t pose_expect_q[$];
    stim_row_t          directed_rows[$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_req        = 0;
    int mismatches      = 0;
    int samples_sent    = 0;
    int poses_checked   = 0;
    int sat_seen        = 0;
    int cfg_writes      = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Dead-reckoning step: wheel distances, heading step, CORDIC, pose update.
    function automatic ddo_pkg::out_item_t odometry_step(ddo_pkg::in_item_t s);
        ddo_pkg::out_item_t r;
        longint      f, hb, dl, dr, diff, den, mag, q, step, z, cx, cy, tx, sum, dx, dy;
        longint      nx, ny;
        logic [15:0] stepw;
        bit          fold, sat;
        f    = (update_rate == 0) ? 1 : longint'(update_rate);
        hb   = (half_base == 0) ? 1 : longint'(half_base);
        dl   = longint'(s.left_wheel_rate) * longint'(left_radius) / f;
        dr   = longint'(s.right_wheel_rate) * longint'(right_radius) / f;
        diff = dr - dl;
        den  = hb * 205887;
        mag  = (diff < 0) ? -diff : diff;
        q    = ((mag << 20) + den / 2) / den;   // round half away from zero
        step = (diff < 0) ? -q : q;
        stepw   = step[15:0];
        heading = heading + stepw;

        // rotation-mode CORDIC, angle folded into the right half plane
        z = longint'(heading) << 16;
        if (z >= 64'sd2147483648)
            z = z - 64'sd4294967296;
        fold = 1'b0;
        if (z > 64'sd1073741824)
        begin
            z    = z - 64'sd2147483648;
            fold = 1'b1;
        end
        else if (z < -64'sd1073741824)
        begin
            z    = z + 64'sd2147483648;
            fold = 1'b1;
        end
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            tx = cx;
            if (z >= 0)
            begin
                cx = cx - (cy >>> i);
                cy = cy + (tx >>> i);
                z  = z - ATAN[i];
            end
            else
            begin
                cx = cx + (cy >>> i);
                cy = cy - (tx >>> i);
                z  = z + ATAN[i];
            end
        end
        if (fold)
        begin
            cx = -cx;
            cy = -cy;
        end

        sum = dl + dr;
        dx  = (sum * cx + 64'sd4294967296) >>> 33;
        dy  = (sum * cy + 64'sd4294967296) >>> 33;
        sat = 1'b0;
        nx  = pose_x + dx;
        ny  = pose_y + dy;
        if (nx > 64'sd2147483647)
        begin
            nx  = 64'sd2147483647;
            sat = 1'b1;
        end
        else if (nx < -64'sd2147483648)
        begin
            nx  = -64'sd2147483648;
            sat = 1'b1;
        end
        if (ny > 64'sd2147483647)
        begin
            ny  = 64'sd2147483647;
            sat = 1'b1;
        end
        else if (ny < -64'sd2147483648)
        begin
            ny  = -64'sd2147483648;
            sat = 1'b1;
        end
        pose_x = nx;
        pose_y = ny;

        r.pos_x         = nx[31:0];
        r.pos_y         = ny[31:0];
        r.heading_out   = heading;
        r.heading_step  = stepw;
        r.pos_saturated = sat;
        return r;
    endfunction

    // Offer one sample; lower valid only on an idle cycle so it never toggles
    // twice in one step.
    task automatic send_sample(ddo_pkg::in_item_t s, bit fixed,
                               ddo_pkg::out_item_t fixed_pose);
        ddo_pkg::out_item_t p;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = odometry_step(s);
        pose_expect_q.push_back(fixed ? fixed_pose : p);
        samples_sent++;
    endtask

    // Wait for the pipe to empty, then let the sequencer settle.
    task automatic drain;
        in_valid <= 1'b0;
        while (pose_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Register write, block idle; mirrored into the bench copy.
    task automatic cfg_write(logic [2:0] addr, logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_writes++;
        case (addr)
            ddo_pkg::CFG_LEFT_RADIUS:  left_radius  = value;
            ddo_pkg::CFG_RIGHT_RADIUS: right_radius = value;
            ddo_pkg::CFG_HALF_BASE:    half_base    = value;
            ddo_pkg::CFG_UPDATE_RATE:  update_rate  = value[9:0];
            default: ;
        endcase
    endtask

    function automatic void add_item(int l, int r);
        stim_row_t row;
        row = '{kind: ROW_ITEM, addr: '0, value: '0, sample: '0, fixed: 1'b0, pose: '0};
        row.sample.left_wheel_rate  = l[15:0];
        row.sample.right_wheel_rate = r[15:0];
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [2:0] addr, logic [15:0] value);
        stim_row_t row;
        row = '{kind: ROW_CFG, addr: addr, value: value, sample: '0, fixed: 1'b0, pose: '0};
        directed_rows.push_back(row);
    endfunction

    // Random wheel rate: mostly full range, sometimes small or extreme.
    function automatic logic [15:0] rand_rate;
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return 16'($signed($urandom_range(400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_reg(logic [15:0] reset_val, int hi);
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'(hi);
            2:       return reset_val;
            3:       return 16'($urandom_range(1, 8));
            default: return 16'($urandom_range(hi));
        endcase
    endfunction

    // Receiver: check each result transfer, stall at random, and serve
    // long hold-off requests from the stimulus thread.
    task automatic check_pose(ddo_pkg::out_item_t got);
        ddo_pkg::out_item_t want;
        bit                 bad;
        if (pose_expect_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result transfer %p", $realtime, got);
        end
        else
        begin
            want = pose_expect_q.pop_front();
            bad  = (got.pos_x !== want.pos_x) || (got.pos_y !== want.pos_y)
                || (got.heading_out !== want.heading_out)
                || (got.heading_step !== want.heading_step)
                || (got.pos_saturated !== want.pos_saturated);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: pose mismatch\n  expected %p\n  actual   %p",
                             $realtime, want, got);
            end
            poses_checked++;
            if (got.pos_saturated === 1'b1)
                sat_seen++;
        end
    endtask

    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_pose(out_data);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: only cycles with no transfer on either channel count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("differential_drive_odometry regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        ddo_pkg::in_item_t  s;
        ddo_pkg::out_item_t zero_pose;

        left_radius  = ddo_pkg::RESET_RADIUS;
        right_radius = ddo_pkg::RESET_RADIUS;
        half_base    = ddo_pkg::RESET_HALF_BASE;
        update_rate  = ddo_pkg::RESET_RATE;
        pose_x       = 0;
        pose_y       = 0;
        heading      = '0;
        zero_pose    = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed table ----
        add_item(0, 0);
        directed_rows[0].fixed = 1'b1;       // after reset: nothing moves
        directed_rows[0].pose  = zero_pose;
        add_item(32767, 32767);
        add_item(-32768, -32768);
        add_item(32767, -32768);
        add_item(-32768, 32767);
        add_item(1, -1);
        add_item(21845, -21846);             // alternating bit patterns
        add_cfg(ddo_pkg::CFG_UPDATE_RATE, 16'd0);     // zero rate acts as one
        add_item(32767, 32767);
        add_cfg(ddo_pkg::CFG_UPDATE_RATE, 16'd1023);  // above the nominal range
        add_item(-32768, 12345);
        add_cfg(ddo_pkg::CFG_HALF_BASE, 16'd0);       // zero half base; huge steps wrap
        add_item(32767, -32768);
        add_item(-100, 100);
        add_cfg(ddo_pkg::CFG_LEFT_RADIUS, 16'd0);     // zero radius: no left distance
        add_item(5000, 5000);
        add_cfg(CFG_UNUSED, 16'hFFFF);                // unknown index, ignored
        add_item(100, 200);
        add_cfg(ddo_pkg::CFG_LEFT_RADIUS, 16'hFFFF);  // largest wheels, rate 1: drives
        add_cfg(ddo_pkg::CFG_RIGHT_RADIUS, 16'hFFFF); // the position into its limits
        add_cfg(ddo_pkg::CFG_HALF_BASE, 16'hFFFF);
        add_cfg(ddo_pkg::CFG_UPDATE_RATE, 16'd1);
        repeat (6) add_item(32767, 32767);
        repeat (2) add_item(-32768, -32768);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain;
                cfg_write(directed_rows[i].addr, directed_rows[i].value);
            end
            else
                send_sample(directed_rows[i].sample, directed_rows[i].fixed,
                            directed_rows[i].pose);
        end

        // ---- random phases: new registers each phase, idling varies ----
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain;   // sender pauses until every result is back
            case (ph % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 53;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 53;
                end
                default:
                begin
                    sender_idle_pct = 9;
                    recv_stall_pct  = 9;
                end
            endcase
            if (ph == 0)
            begin
                cfg_write(ddo_pkg::CFG_LEFT_RADIUS, ddo_pkg::RESET_RADIUS);
                cfg_write(ddo_pkg::CFG_RIGHT_RADIUS, ddo_pkg::RESET_RADIUS);
                cfg_write(ddo_pkg::CFG_HALF_BASE, ddo_pkg::RESET_HALF_BASE);
                cfg_write(ddo_pkg::CFG_UPDATE_RATE, 16'(ddo_pkg::RESET_RATE));
            end
            else
            begin
                cfg_write(ddo_pkg::CFG_LEFT_RADIUS,
                          rand_reg(ddo_pkg::RESET_RADIUS, 65535));
                cfg_write(ddo_pkg::CFG_RIGHT_RADIUS,
                          rand_reg(ddo_pkg::RESET_RADIUS, 65535));
                cfg_write(ddo_pkg::CFG_HALF_BASE,
                          rand_reg(ddo_pkg::RESET_HALF_BASE, 65535));
                cfg_write(ddo_pkg::CFG_UPDATE_RATE,
                          rand_reg(16'(ddo_pkg::RESET_RATE), 1023));
            end
            if (ph == 3)
                cfg_write(3'($urandom_range(4, 7)), 16'($urandom));

            // one long receiver hold-off while samples keep coming
            if (ph == 1)
            begin
                sender_idle_pct = 0;
                hold_req++;
                repeat (10)
                begin
                    s.left_wheel_rate  = rand_rate();
                    s.right_wheel_rate = rand_rate();
                    send_sample(s, 1'b0, zero_pose);
                end
                sender_idle_pct = 53;
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                s.left_wheel_rate  = rand_rate();
                s.right_wheel_rate = ($urandom_range(3) == 0) ? s.left_wheel_rate
                                                               : rand_rate();
                send_sample(s, 1'b0, zero_pose);
            end
        end

        drain;

        $display("covered %0d samples, %0d results checked, %0d saturated, %0d register writes",
                 samples_sent, poses_checked, sat_seen, cfg_writes);
        $display("idle mixes: none, sender 53%%, receiver 53%%, both 9%%; one long hold-off");
        if (mismatches == 0 && pose_expect_q.size() == 0)
            $display("differential_drive_odometry regression: pass");
        else
            $display("differential_drive_odometry regression: fail");
        $finish;
    end

endmodule

### files.f
rtl/ddo_pkg.sv
rtl/ddo_front.sv
rtl/ddo_queue.sv
rtl/ddo_back.sv
rtl/differential_drive_odometry.sv
test/differential_drive_odometry_tb.sv
